### rtl/spoc_pkg.sv
// spoc_pkg: shared types and constants of the stack pop order checker
// used by the channel interfaces, the stack unit and the top level

package spoc_pkg;

	// width of a value of the pop order and of a stored stack entry
	localparam int VAL_W = 11;
	// width of the configuration data
	localparam int CFG_W = 11;
	localparam int CAP_W = 7;

	// status codes of a result item
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_ORDER    = 2'd2,
		STATUS_RANGE    = 2'd3
	} spoc_status_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_STACK_CAPACITY  = 1'b0,
		REG_SEQUENCE_LENGTH = 1'b1
	} spoc_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_PUSH  = 2'd1,
		ST_FETCH = 2'd2,
		ST_DONE  = 2'd3
	} spoc_state_t;

	// commands from the sequencer to the stack unit
	typedef struct packed {
		logic push;
		logic pop;
		logic reload;
		logic clear;
	} spoc_stk_cmd_t;

endpackage

### rtl/spoc_in_if.sv
// spoc_in_if: input channel carrying one claimed pop value per item
// depends on spoc_pkg for the value width

interface spoc_in_if;
	logic                      valid;
	logic                      ready;
	logic [spoc_pkg::VAL_W-1:0] pop_value;
	logic                      last;

	modport source (output valid, output pop_value, output last, input ready);
	modport sink   (input valid, input pop_value, input last, output ready);
endinterface

### rtl/spoc_out_if.sv
// spoc_out_if: output channel carrying one verdict per item
// depends on spoc_pkg for the status type

interface spoc_out_if;
	logic                       valid;
	logic                       ready;
	spoc_pkg::spoc_status_t     status;
	logic                       sequence_end;

	modport source (output valid, output status, output sequence_end, input ready);
	modport sink   (input valid, input status, input sequence_end, output ready);
endinterface

### rtl/spoc_stack.sv
// spoc_stack: stack storage with a memory that has one write port and one registered read port, and a top register
// depends on spoc_pkg for the command struct and value width

module spoc_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int CNT_W       = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spoc_pkg::spoc_stk_cmd_t    cmd,
	input  logic [spoc_pkg::VAL_W-1:0] push_val,
	output logic [CNT_W-1:0]           count,
	output logic [spoc_pkg::VAL_W-1:0] top
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [spoc_pkg::VAL_W-1:0] mem [STACK_DEPTH];
	logic [spoc_pkg::VAL_W-1:0] rd_q;
	logic [spoc_pkg::VAL_W-1:0] top_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           below_top;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;

	// entry under the current top becomes the top after a pop
	assign below_top = count_q - CNT_W'(2);
	assign rd_addr   = below_top[AW-1:0];
	assign wr_addr   = count_q[AW-1:0];

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= push_val;
		end
		rd_q <= mem[rd_addr];
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// cached top entry
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= push_val;
		end else if (cmd.reload) begin
			top_q <= rd_q;
		end
	end

	assign count = count_q;
	assign top   = top_q;

endmodule

### rtl/stack_pop_order_checker.sv
// stack_pop_order_checker: top level with the sequencer, registers and output stage
// depends on spoc_pkg, spoc_in_if, spoc_out_if and spoc_stack

// Checks a stream of claimed pop values against a stack fed with 1..N in order.
// Each accepted item gives one verdict item: ok so far, overflow, order violation
// or value out of range; the first error of a sequence sticks until an item with
// last set closes it. One shared compare step under a small sequencer pushes one
// number per cycle into the stack memory; an item goes from IDLE through PUSH
// (pushes, then the pop) and FETCH (when a pop must refetch the new top) to DONE,
// or from IDLE straight to DONE after a sticky error or with an out-of-range value.
// Over a whole sequence pushes total at most N. The verdict sits in an output
// register, so the next item is taken while it waits. The user writes configuration
// through cfg_we, cfg_index and cfg_data while idle; the block does not enforce it.

module stack_pop_order_checker #(
	parameter int MAX_LEN     = 1024,
	parameter int STACK_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	spoc_in_if.sink                    pop,
	spoc_out_if.source                 verdict,
	input  logic                       cfg_we,
	input  spoc_pkg::spoc_reg_t        cfg_index,
	input  logic [spoc_pkg::CFG_W-1:0] cfg_data
);

	localparam int VAL_W  = spoc_pkg::VAL_W;
	localparam int CAP_W  = spoc_pkg::CAP_W;
	localparam int NP_W   = VAL_W + 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int LenLim = (MAX_LEN < 2047) ? MAX_LEN : 2047;
	localparam int CapLim = (STACK_DEPTH < 127) ? STACK_DEPTH : 127;
	localparam logic [VAL_W-1:0] LEN_LIM = VAL_W'(LenLim);
	localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(CapLim);

	spoc_pkg::spoc_state_t   state_q, state_d;
	spoc_pkg::spoc_stk_cmd_t cmd;
	spoc_pkg::spoc_status_t  err_q, err_d, status_q;

	logic [CAP_W-1:0] capacity_q;
	logic [VAL_W-1:0] length_q;
	logic [NP_W-1:0]  next_push_q;
	logic [VAL_W-1:0] value_q;
	logic             last_q;
	logic             out_valid_q;
	logic             end_q;

	logic [CNT_W-1:0] count;
	logic [VAL_W-1:0] top;
	logic [VAL_W-1:0] len_eff;
	logic [CAP_W-1:0] cap_eff;
	logic             range_bad;
	logic             need_push;
	logic             full;
	logic             match;
	logic             accept;
	logic             err_set;
	logic             out_free;
	logic             out_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(64);
			length_q   <= VAL_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				spoc_pkg::REG_STACK_CAPACITY:  capacity_q <= cfg_data[CAP_W-1:0];
				spoc_pkg::REG_SEQUENCE_LENGTH: length_q   <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// effective limits and the shared compare step
	assign len_eff   = (length_q > LEN_LIM) ? LEN_LIM : length_q;
	assign cap_eff   = (capacity_q > CAP_LIM) ? CAP_LIM : capacity_q;
	assign range_bad = (pop.pop_value == '0) || (pop.pop_value > len_eff);
	assign need_push = next_push_q <= {1'b0, value_q};
	assign full      = CMP_W'(count) >= CMP_W'(cap_eff);
	assign match     = (count != '0) && (top == value_q);
	assign accept    = pop.valid && pop.ready;
	assign out_free  = !out_valid_q || verdict.ready;

	assign pop.ready = (state_q == spoc_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spoc_pkg::ST_IDLE: begin
				if (pop.valid) begin
					if (err_q != spoc_pkg::STATUS_OK || range_bad) begin
						state_d = spoc_pkg::ST_DONE;
					end else begin
						state_d = spoc_pkg::ST_PUSH;
					end
				end
			end
			spoc_pkg::ST_PUSH: begin
				if (need_push) begin
					if (full) begin
						state_d = spoc_pkg::ST_DONE;
					end
				end else if (match && count >= CNT_W'(2)) begin
					state_d = spoc_pkg::ST_FETCH;
				end else begin
					state_d = spoc_pkg::ST_DONE;
				end
			end
			spoc_pkg::ST_FETCH: state_d = spoc_pkg::ST_DONE;
			spoc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = spoc_pkg::ST_IDLE;
				end
			end
			default: state_d = spoc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd      = '0;
		err_set  = 1'b0;
		err_d    = spoc_pkg::STATUS_OK;
		out_load = 1'b0;
		case (state_q)
			spoc_pkg::ST_IDLE: begin
				if (pop.valid && err_q == spoc_pkg::STATUS_OK && range_bad) begin
					err_set = 1'b1;
					err_d   = spoc_pkg::STATUS_RANGE;
				end
			end
			spoc_pkg::ST_PUSH: begin
				if (need_push) begin
					if (full) begin
						err_set = 1'b1;
						err_d   = spoc_pkg::STATUS_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (match) begin
					cmd.pop = 1'b1;
				end else begin
					err_set = 1'b1;
					err_d   = spoc_pkg::STATUS_ORDER;
				end
			end
			spoc_pkg::ST_FETCH: cmd.reload = 1'b1;
			spoc_pkg::ST_DONE: begin
				out_load  = out_free;
				cmd.clear = out_free && last_q;
			end
			default: ;
		endcase
	end

	// sequencer and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spoc_pkg::ST_IDLE;
			err_q       <= spoc_pkg::STATUS_OK;
			next_push_q <= NP_W'(1);
		end else begin
			state_q <= state_d;
			if (cmd.clear) begin
				err_q       <= spoc_pkg::STATUS_OK;
				next_push_q <= NP_W'(1);
			end else begin
				if (err_set) begin
					err_q <= err_d;
				end
				if (cmd.push) begin
					next_push_q <= next_push_q + NP_W'(1);
				end
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= pop.pop_value;
			last_q  <= pop.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= err_q;
			end_q    <= last_q;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.status       = status_q;
	assign verdict.sequence_end = end_q;

	spoc_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.CNT_W      (CNT_W)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.push_val(next_push_q[VAL_W-1:0]),
		.count   (count),
		.top     (top)
	);

	// stack never holds more than its storage
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count) <= CMP_W'(STACK_DEPTH))
		else $error("stack count beyond storage");

	// a push only happens below the effective capacity
	a_push_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (CMP_W'(count) < CMP_W'(cap_eff)))
		else $error("push past capacity");

	// closing a sequence returns to the reset state of the sequence
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count == '0 && err_q == spoc_pkg::STATUS_OK
			&& next_push_q == NP_W'(1)))
		else $error("sequence state not cleared");

	// a sticky error skips the stack work entirely
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q != spoc_pkg::STATUS_OK) |=> (state_q == spoc_pkg::ST_DONE))
		else $error("sticky error item entered stack work");

	// an error is never overwritten within a sequence
	a_first_error: assert property (@(posedge clk) disable iff (!arst_n)
		err_set |-> (err_q == spoc_pkg::STATUS_OK))
		else $error("error overwritten");

endmodule

### bench/tb_stack_pop_order_checker.sv
// tb_stack_pop_order_checker: self-checking bench for the stack pop order checker
// drives pop orders through spoc_in_if, checks verdicts from spoc_out_if against a
// local stack predictor; depends on spoc_pkg, spoc_in_if, spoc_out_if and the top level

module tb_stack_pop_order_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_LIMIT  = 64;
	localparam int LENGTH_LIMIT = 1024;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 4;

	typedef struct {
		spoc_pkg::spoc_status_t status;
		logic                   sequence_end;
	} verdict_t;

	typedef struct {
		bit                     is_write;
		spoc_pkg::spoc_reg_t    reg_index;
		int                     data;
		int                     value;
		bit                     last_flag;
		bit                     typed;
		spoc_pkg::spoc_status_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	spoc_pkg::spoc_reg_t cfg_index;
	logic [spoc_pkg::CFG_W-1:0] cfg_data;

	spoc_in_if  pop_ch ();
	spoc_out_if verdict_ch ();

	stack_pop_order_checker #(
		.MAX_LEN     (LENGTH_LIMIT),
		.STACK_DEPTH (DEPTH_LIMIT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop_ch),
		.verdict   (verdict_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of registers and stack
	logic [6:0]   capacity_reg;
	logic [10:0]  length_reg;
	int           next_number;
	int           held [DEPTH_LIMIT];
	int           held_count;
	spoc_pkg::spoc_status_t seq_status;

	verdict_t pending_verdicts [$];
	int       mismatches = 0;
	int       random_items;
	int       cycle_count = 0;
	bit       calm;

	// directed items: typed verdicts only where obvious, the rest from the predictor
	plan_row_t directed_plan [33] = '{
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b1, 1'b1, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    0, 1'b1, 1'b1, spoc_pkg::STATUS_RANGE},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0, 1025, 1'b0, 1'b1, spoc_pkg::STATUS_RANGE},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0, 2047, 1'b1, 1'b1, spoc_pkg::STATUS_RANGE},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0, 1024, 1'b1, 1'b1, spoc_pkg::STATUS_OVERFLOW},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,   64, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,   63, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,   62, 1'b1, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,   65, 1'b1, 1'b1, spoc_pkg::STATUS_OVERFLOW},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    3, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b0, 1'b1, spoc_pkg::STATUS_ORDER},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b1, 1'b1, spoc_pkg::STATUS_ORDER},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b1, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    3, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b1, spoc_pkg::REG_SEQUENCE_LENGTH, 2,    0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    3, 1'b1, 1'b1, spoc_pkg::STATUS_RANGE},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b1, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b1, spoc_pkg::REG_SEQUENCE_LENGTH, 0,    0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b1, 1'b1, spoc_pkg::STATUS_RANGE},
		'{1'b1, spoc_pkg::REG_STACK_CAPACITY,  0,    0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b1, spoc_pkg::REG_SEQUENCE_LENGTH, 2047, 0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b1, 1'b1, spoc_pkg::STATUS_OVERFLOW},
		'{1'b1, spoc_pkg::REG_STACK_CAPACITY,  127,  0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,   64, 1'b1, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b1, spoc_pkg::REG_STACK_CAPACITY,  1,    0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b1, spoc_pkg::REG_SEQUENCE_LENGTH, 1024, 0, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b1, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    1, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    2, 1'b0, 1'b0, spoc_pkg::STATUS_OK},
		'{1'b0, spoc_pkg::REG_STACK_CAPACITY,  0,    3, 1'b1, 1'b0, spoc_pkg::STATUS_OK}
	};

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// bounds clipped to the store depth and the length parameter
	function automatic int usable_capacity();
		return (int'(capacity_reg) > DEPTH_LIMIT) ? DEPTH_LIMIT : int'(capacity_reg);
	endfunction

	function automatic int usable_length();
		return (int'(length_reg) > LENGTH_LIMIT) ? LENGTH_LIMIT : int'(length_reg);
	endfunction

	// push numbers up to the value, then pop it if it is on top
	function automatic spoc_pkg::spoc_status_t judge_value(int value);
		int n_eff;
		int c_eff;
		n_eff = usable_length();
		c_eff = usable_capacity();
		if (value == 0 || value > n_eff)
			return spoc_pkg::STATUS_RANGE;
		while (next_number <= value) begin
			if (held_count >= c_eff)
				return spoc_pkg::STATUS_OVERFLOW;
			held[held_count] = next_number;
			held_count++;
			next_number++;
		end
		if (held_count == 0 || held[held_count-1] != value)
			return spoc_pkg::STATUS_ORDER;
		held_count--;
		return spoc_pkg::STATUS_OK;
	endfunction

	// sticky status per sequence, cleared by the closing item
	function automatic verdict_t predict_verdict(int value, bit is_last);
		verdict_t result;
		if (seq_status == spoc_pkg::STATUS_OK)
			seq_status = judge_value(value);
		result.status = seq_status;
		result.sequence_end = is_last;
		if (is_last) begin
			next_number = 1;
			held_count = 0;
			seq_status = spoc_pkg::STATUS_OK;
		end
		return result;
	endfunction

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 8);
	endfunction

	// offer one item, wait for it to be taken, then log its verdict
	task automatic send_pop(input int value, input bit is_last, input bit use_typed,
			input spoc_pkg::spoc_status_t want);
		verdict_t predicted;
		while (take_break()) begin
			pop_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pop_ch.valid <= 1'b1;
		pop_ch.pop_value <= spoc_pkg::VAL_W'(value);
		pop_ch.last <= is_last;
		do @(posedge clk); while (pop_ch.ready !== 1'b1);
		predicted = predict_verdict(value, is_last);
		if (use_typed)
			predicted.status = want;
		pending_verdicts.push_back(predicted);
	endtask

	// drain all verdicts before touching registers
	task automatic wait_idle();
		pop_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input spoc_pkg::spoc_reg_t index, input int data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= spoc_pkg::CFG_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == spoc_pkg::REG_STACK_CAPACITY)
			capacity_reg = 7'(data);
		else
			length_reg = 11'(data);
		@(posedge clk);
	endtask

	function automatic int pick_capacity();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 64;
			3: return 127;
			4: return $urandom_range(127);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	function automatic int pick_length();
		case ($urandom_range(13))
			0: return 0;
			1: return 1;
			2: return 1024;
			3: return 2047;
			4: return $urandom_range(2047);
			default: return $urandom_range(2, 24);
		endcase
	endfunction

	// one sequence: mostly valid pop orders, some corrupted, some noise
	task automatic run_sequence();
		int values [$];
		int gen_stack [DEPTH_LIMIT];
		int depth;
		int upcoming;
		int target;
		int roll;
		int pos;
		int swap_tmp;
		int n_eff;
		int c_eff;
		n_eff = usable_length();
		c_eff = usable_capacity();
		calm = (random_items >= 450 && random_items < 700);
		roll = $urandom_range(99);
		if (roll < 72 && n_eff > 0 && c_eff > 0) begin
			target = (n_eff > 40) ? $urandom_range(1, 40) : n_eff;
			// sometimes close the sequence early
			if ($urandom_range(4) == 0)
				target = $urandom_range(1, target);
			depth = 0;
			upcoming = 1;
			while (values.size() < target) begin
				if (depth > 0 && (upcoming > n_eff || depth >= c_eff || $urandom_range(1) == 1)) begin
					depth--;
					values.push_back(gen_stack[depth]);
				end else begin
					gen_stack[depth] = upcoming;
					depth++;
					upcoming++;
				end
			end
			// break the order: swap a pair or replace one value
			if (roll >= 56) begin
				pos = $urandom_range(values.size() - 1);
				if (roll[0] && pos + 1 < values.size()) begin
					swap_tmp = values[pos];
					values[pos] = values[pos+1];
					values[pos+1] = swap_tmp;
				end else begin
					values[pos] = $urandom_range(n_eff + 1);
				end
			end
		end else begin
			target = $urandom_range(1, 6);
			repeat (target)
				values.push_back(($urandom_range(3) == 0) ? $urandom_range(2047) :
					$urandom_range(n_eff + 2));
		end
		foreach (values[i])
			send_pop(values[i], i == values.size() - 1, 1'b0, spoc_pkg::STATUS_OK);
		random_items += values.size();
	endtask

	// verdict checker and random backpressure
	always @(posedge clk) begin
		verdict_t oldest;
		if (arst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: verdict with none expected, status %0d end %0b",
					$time, verdict_ch.status, verdict_ch.sequence_end);
				mismatches++;
			end else begin
				oldest = pending_verdicts.pop_front();
				if (verdict_ch.status !== oldest.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, oldest.status, verdict_ch.status);
					mismatches++;
				end
				if (verdict_ch.sequence_end !== oldest.sequence_end) begin
					$display("%0t: sequence_end expected %0b, got %0b",
						$time, oldest.sequence_end, verdict_ch.sequence_end);
					mismatches++;
				end
			end
		end
		verdict_ch.ready <= calm || ($urandom_range(99) >= 8);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = spoc_pkg::REG_STACK_CAPACITY;
		cfg_data = '0;
		pop_ch.valid = 1'b0;
		pop_ch.pop_value = '0;
		pop_ch.last = 1'b0;
		capacity_reg = 7'd64;
		length_reg = 11'd1024;
		next_number = 1;
		held_count = 0;
		seq_status = spoc_pkg::STATUS_OK;
		random_items = 0;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write) begin
				wait_idle();
				write_reg(directed_plan[i].reg_index, directed_plan[i].data);
			end else begin
				send_pop(directed_plan[i].value, directed_plan[i].last_flag,
					directed_plan[i].typed, directed_plan[i].want);
			end
		end

		// random phases, each with fresh register settings
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			write_reg(spoc_pkg::REG_STACK_CAPACITY, pick_capacity());
			write_reg(spoc_pkg::REG_SEQUENCE_LENGTH, pick_length());
			repeat ($urandom_range(3, 8))
				run_sequence();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
